[hw/rtl/c8_exec_pkg.sv]
// ----------------------------------------------------------------------------
// c8_exec_pkg
// Shared types and constants for the CHIP-8 instruction execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c8_exec_pkg;

  // Default number of return stack entries
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [15:0] OP_CLS   = 16'h00E0;
  localparam logic [15:0] OP_RET   = 16'h00EE;
  localparam logic [3:0]  FLAG_REG = 4'hF;
  localparam logic [3:0]  ZERO_REG = 4'h0;

  // Stack error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  // Opcode groups (bits 15..12)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDIX = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;

  // ALU codes (bits 3..0 of the 8XY group)
  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef struct packed {
    logic [15:0] opcode;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic        clear_screen;
    logic [1:0]  stack_error;
    logic [7:0]  vx_value;
    logic [7:0]  vf_value;
    logic [11:0] index_value;
  } out_item_t;

  // Register file write port
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } rf_wr_t;

endpackage

`default_nettype wire

[hw/rtl/c8_exec_regfile.sv]
// ----------------------------------------------------------------------------
// c8_exec_regfile
// General register memory: one write port, two registered read ports.
// Entries never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c8_exec_regfile (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire c8_exec_pkg::rf_wr_t wr,
  input  wire                   rd_en,
  input  wire [3:0]             rd_addr_x,
  input  wire [3:0]             rd_addr_y,
  output logic [7:0]            rd_data_x,
  output logic [7:0]            rd_data_y
);

  logic [7:0]  mem [16];
  logic [15:0] vld_r;
  logic [7:0]  data_x_r;
  logic [7:0]  data_y_r;
  logic        ok_x_r;
  logic        ok_y_r;

  // Track which entries hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Write and read the array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      data_x_r <= mem[rd_addr_x];
      data_y_r <= mem[rd_addr_y];
      ok_x_r   <= vld_r[rd_addr_x];
      ok_y_r   <= vld_r[rd_addr_y];
    end
  end

  assign rd_data_x = ok_x_r ? data_x_r : 8'h00;
  assign rd_data_y = ok_y_r ? data_y_r : 8'h00;

endmodule

`default_nettype wire

[hw/rtl/c8_exec_stack.sv]
// ----------------------------------------------------------------------------
// c8_exec_stack
// Return stack memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c8_exec_stack #(
  parameter int STACK_DEPTH = c8_exec_pkg::STACK_DEPTH_DEF,
  localparam int IW = $clog2(STACK_DEPTH)
) (
  input  wire             clk,
  input  wire             wr_en,
  input  wire  [IW-1:0]   wr_addr,
  input  wire  [11:0]     wr_data,
  input  wire             rd_en,
  input  wire  [IW-1:0]   rd_addr,
  output logic [11:0]     rd_data
);

  logic [11:0] mem [STACK_DEPTH];

  // Write and read the array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/chip8_instruction_execute_top.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top
// CHIP-8 execute core: one opcode in, one machine-state report out.
// ----------------------------------------------------------------------------
// The block takes one opcode per clock while the output is not stalled and
// returns one result per opcode, in order, via the execute stage register
// and the output register. The opcode's register and return stack reads are
// issued at the transfer edge; the execute stage then executes it and, when
// it advances, writes the register file, stack and PC and loads the output
// register. The rate of one opcode per cycle rests on the read-modify-write
// of the register file, with the write of the executing opcode bypassed into
// the reads of the one behind it. V0 is mirrored in a flip-flop for BNNN; VF,
// the flag target, lives only in a flip-flop. After reset the PC is 0x200 and
// all registers read zero; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module chip8_instruction_execute_top #(
  parameter int STACK_DEPTH = c8_exec_pkg::STACK_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire c8_exec_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output c8_exec_pkg::out_item_t  out_data
);

  localparam int IW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  // Execute stage
  logic                  s1_vld_r;
  c8_exec_pkg::in_item_t s1_r;
  logic                  bx_vld_r, by_vld_r, bs_vld_r;
  logic [7:0]            bx_data_r, by_data_r;
  logic [11:0]           bs_data_r;

  // Architectural state in flops
  logic [11:0]    pc_r, pc_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [11:0]    idx_r, idx_nxt;
  logic [7:0]     vf_r, vf_nxt;
  logic [7:0]     v0_r, v0_nxt;

  // Output register
  logic                   out_vld_r;
  c8_exec_pkg::out_item_t out_r;

  logic in_xfer;
  logic s1_go;

  // Memory ports
  c8_exec_pkg::rf_wr_t rf_wr;
  logic [7:0]          rf_x, rf_y;
  logic                stk_we;
  logic [IW-1:0]       stk_waddr;
  logic [IW-1:0]       stk_raddr;
  logic [11:0]         stk_rdata;
  logic [SPW-1:0]      sp_eff;
  logic [SPW-1:0]      sp_m1;

  // Execute signals
  logic [3:0]  x, y, grp, alu;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [7:0]  vx, vy;
  logic [11:0] pc_inc, pc_skip, ret_pc;
  logic [8:0]  sum9;
  logic        wr_en;
  logic [7:0]  wr_val;
  logic        flag_en;
  logic        flag_val;
  logic        cls;
  logic [1:0]  err;
  logic [7:0]  vx_final;

  // Handshake: stage advances when the output register is free or leaving
  assign s1_go    = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  // Field split
  assign grp = s1_r.opcode[15:12];
  assign x   = s1_r.opcode[11:8];
  assign y   = s1_r.opcode[7:4];
  assign alu = s1_r.opcode[3:0];
  assign kk  = s1_r.opcode[7:0];
  assign nnn = s1_r.opcode[11:0];

  // Operands: VF from its flop, others from memory with bypass
  assign vx = (x == c8_exec_pkg::FLAG_REG) ? vf_r : (bx_vld_r ? bx_data_r : rf_x);
  assign vy = (y == c8_exec_pkg::FLAG_REG) ? vf_r : (by_vld_r ? by_data_r : rf_y);
  assign ret_pc  = bs_vld_r ? bs_data_r : stk_rdata;
  assign pc_inc  = pc_r + 12'd1;
  assign pc_skip = pc_r + 12'd2;
  assign sum9    = {1'b0, vx} + {1'b0, vy};

  // Decode and execute
  always_comb begin
    pc_nxt    = pc_inc;
    sp_nxt    = sp_r;
    idx_nxt   = idx_r;
    wr_en     = 1'b0;
    wr_val    = vx;
    flag_en   = 1'b0;
    flag_val  = 1'b0;
    cls       = 1'b0;
    err       = c8_exec_pkg::ERR_NONE;
    stk_we    = 1'b0;
    stk_waddr = sp_r[IW-1:0];
    case (grp)
      c8_exec_pkg::GRP_SYS: begin
        if (s1_r.opcode == c8_exec_pkg::OP_CLS) begin
          cls = 1'b1;
        end else if (s1_r.opcode == c8_exec_pkg::OP_RET) begin
          if (sp_r == '0) begin
            err = c8_exec_pkg::ERR_UNDERFLOW;
          end else begin
            sp_nxt = sp_r - SPW'(1);
            pc_nxt = ret_pc;
          end
        end else begin
          pc_nxt = nnn;
        end
      end
      c8_exec_pkg::GRP_JP:   pc_nxt = nnn;
      c8_exec_pkg::GRP_CALL: begin
        if (sp_r >= SPW'(STACK_DEPTH)) begin
          err = c8_exec_pkg::ERR_OVERFLOW;
        end else begin
          stk_we = 1'b1;
          sp_nxt = sp_r + SPW'(1);
          pc_nxt = nnn;
        end
      end
      c8_exec_pkg::GRP_SEI:  if (vx == kk) pc_nxt = pc_skip;
      c8_exec_pkg::GRP_SNEI: if (vx != kk) pc_nxt = pc_skip;
      c8_exec_pkg::GRP_SER:  if (vx == vy) pc_nxt = pc_skip;
      c8_exec_pkg::GRP_SNER: if (vx != vy) pc_nxt = pc_skip;
      c8_exec_pkg::GRP_LDI: begin
        wr_en  = 1'b1;
        wr_val = kk;
      end
      c8_exec_pkg::GRP_ADDI: begin
        wr_en  = 1'b1;
        wr_val = vx + kk;
      end
      c8_exec_pkg::GRP_ALU: begin
        case (alu)
          c8_exec_pkg::ALU_LD:  begin wr_en = 1'b1; wr_val = vy; end
          c8_exec_pkg::ALU_OR:  begin wr_en = 1'b1; wr_val = vx | vy; end
          c8_exec_pkg::ALU_AND: begin wr_en = 1'b1; wr_val = vx & vy; end
          c8_exec_pkg::ALU_XOR: begin wr_en = 1'b1; wr_val = vx ^ vy; end
          c8_exec_pkg::ALU_ADD: begin
            wr_en = 1'b1; wr_val = sum9[7:0];
            flag_en = 1'b1; flag_val = sum9[8];
          end
          c8_exec_pkg::ALU_SUB: begin
            wr_en = 1'b1; wr_val = vx - vy;
            flag_en = 1'b1; flag_val = (vx > vy);
          end
          c8_exec_pkg::ALU_SHR: begin
            wr_en = 1'b1; wr_val = {1'b0, vx[7:1]};
            flag_en = 1'b1; flag_val = vx[0];
          end
          c8_exec_pkg::ALU_SUBN: begin
            wr_en = 1'b1; wr_val = vy - vx;
            flag_en = 1'b1; flag_val = (vy > vx);
          end
          c8_exec_pkg::ALU_SHL: begin
            wr_en = 1'b1; wr_val = {vx[6:0], 1'b0};
            flag_en = 1'b1; flag_val = vx[7];
          end
          default: ;
        endcase
      end
      c8_exec_pkg::GRP_LDIX: idx_nxt = nnn;
      c8_exec_pkg::GRP_JPV0: pc_nxt = {4'h0, v0_r} + nnn;
      c8_exec_pkg::GRP_RND: begin
        wr_en  = 1'b1;
        wr_val = s1_r.random_byte & kk;
      end
      default: ;
    endcase
  end

  // Resolve register targets: flag overrides a write to VF
  always_comb begin
    vf_nxt = vf_r;
    v0_nxt = v0_r;
    if (wr_en && x == c8_exec_pkg::FLAG_REG) vf_nxt = wr_val;
    if (wr_en && x == c8_exec_pkg::ZERO_REG) v0_nxt = wr_val;
    if (flag_en) vf_nxt = {7'd0, flag_val};
    vx_final = (x == c8_exec_pkg::FLAG_REG) ? vf_nxt : (wr_en ? wr_val : vx);
  end

  assign rf_wr.en   = s1_go && wr_en && (x != c8_exec_pkg::FLAG_REG);
  assign rf_wr.addr = x;
  assign rf_wr.data = wr_val;

  // Stack read address follows the pointer left by the executing opcode
  assign sp_eff    = s1_go ? sp_nxt : sp_r;
  assign sp_m1     = sp_eff - SPW'(1);
  assign stk_raddr = sp_m1[IW-1:0];

  c8_exec_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (rf_wr),
    .rd_en     (in_xfer),
    .rd_addr_x (in_data.opcode[11:8]),
    .rd_addr_y (in_data.opcode[7:4]),
    .rd_data_x (rf_x),
    .rd_data_y (rf_y)
  );

  c8_exec_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (s1_go && stk_we),
    .wr_addr (stk_waddr),
    .wr_data (pc_inc),
    .rd_en   (in_xfer),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  // Capture the opcode and bypass any write landing at the read edge
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r      <= in_data;
      bx_vld_r  <= rf_wr.en && (rf_wr.addr == in_data.opcode[11:8]);
      by_vld_r  <= rf_wr.en && (rf_wr.addr == in_data.opcode[7:4]);
      bx_data_r <= rf_wr.data;
      by_data_r <= rf_wr.data;
      bs_vld_r  <= s1_go && stk_we && (stk_waddr == stk_raddr);
      bs_data_r <= pc_inc;
    end
  end

  // Advance control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= c8_exec_pkg::PC_RESET;
      sp_r      <= '0;
      idx_r     <= '0;
      vf_r      <= '0;
      v0_r      <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        out_vld_r <= 1'b1;
        pc_r      <= pc_nxt;
        sp_r      <= sp_nxt;
        idx_r     <= idx_nxt;
        vf_r      <= vf_nxt;
        v0_r      <= v0_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_r.next_pc      <= pc_nxt;
      out_r.clear_screen <= cls;
      out_r.stack_error  <= err;
      out_r.vx_value     <= vx_final;
      out_r.vf_value     <= vf_nxt;
      out_r.index_value  <= idx_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_err_sp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && err != c8_exec_pkg::ERR_NONE) |=> (sp_r == $past(sp_r)))
    else $error("stack pointer moved on stack error");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r))
    else $error("input stalled with free pipeline");

  a_cls_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.clear_screen) |-> (out_r.stack_error == c8_exec_pkg::ERR_NONE))
    else $error("clear screen reported with stack error");

endmodule

`default_nettype wire

[tb/chip8_instruction_execute_top_tb.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top_tb
// Self-checking bench for the CHIP-8 execute core. A behavioral tracker keeps
// its own registers, PC, index and return stack, predicts one report per
// opcode and checks every report in order. The stimulus has a directed opcode
// list, then random opcodes steered by the tracked state, call/return bursts,
// random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chip8_instruction_execute_top_tb;

  localparam int DEPTH     = c8_exec_pkg::STACK_DEPTH_DEF;
  localparam int LIMIT     = 150000;
  localparam int LONG_HOLD = 60;

  // Opcode tracker: predicts each report and checks it in transfer order
  class exec_tracker;
    logic [7:0]  vreg [16];
    logic [11:0] pc;
    logic [11:0] ireg;
    logic [11:0] ret_stack [DEPTH];
    int          sp;
    c8_exec_pkg::out_item_t reports_due [$];
    int          errors;
    int          n_taken;
    int          n_checked;
    int          n_overflow;
    int          n_underflow;
    int          n_cls;

    function new();
      foreach (vreg[i]) vreg[i] = 8'h00;
      pc   = c8_exec_pkg::PC_RESET;
      ireg = 12'h000;
      sp   = 0;
    endfunction

    function void write_flag(logic [3:0] x, logic [7:0] val, logic flag);
      vreg[x]                     = val;
      vreg[c8_exec_pkg::FLAG_REG] = {7'd0, flag};
    endfunction

    // Execute one opcode and queue the report it produces
    function void take_opcode(c8_exec_pkg::in_item_t it);
      logic [15:0] op;
      logic [3:0]  x;
      logic [3:0]  y;
      logic [7:0]  kk;
      logic [7:0]  vx;
      logic [7:0]  vy;
      logic [11:0] nnn;
      logic [11:0] npc;
      logic [11:0] skp;
      logic [8:0]  sum;
      logic [1:0]  err;
      logic        cls;
      c8_exec_pkg::out_item_t rep;
      op  = it.opcode;
      x   = op[11:8];
      y   = op[7:4];
      kk  = op[7:0];
      nnn = op[11:0];
      vx  = vreg[x];
      vy  = vreg[y];
      npc = pc + 12'd1;
      skp = pc + 12'd2;
      err = c8_exec_pkg::ERR_NONE;
      cls = 1'b0;
      case (op[15:12])
        c8_exec_pkg::GRP_SYS: begin
          if (op == c8_exec_pkg::OP_CLS) begin
            cls = 1'b1;
          end else if (op == c8_exec_pkg::OP_RET) begin
            if (sp == 0) begin
              err = c8_exec_pkg::ERR_UNDERFLOW;
            end else begin
              sp--;
              npc = ret_stack[sp];
            end
          end else begin
            npc = nnn;
          end
        end
        c8_exec_pkg::GRP_JP: npc = nnn;
        c8_exec_pkg::GRP_CALL: begin
          if (sp >= DEPTH) begin
            err = c8_exec_pkg::ERR_OVERFLOW;
          end else begin
            ret_stack[sp] = npc;
            sp++;
            npc = nnn;
          end
        end
        c8_exec_pkg::GRP_SEI:  if (vx == kk) npc = skp;
        c8_exec_pkg::GRP_SNEI: if (vx != kk) npc = skp;
        c8_exec_pkg::GRP_SER:  if (vx == vy) npc = skp;
        c8_exec_pkg::GRP_LDI:  vreg[x] = kk;
        c8_exec_pkg::GRP_ADDI: vreg[x] = vx + kk;
        c8_exec_pkg::GRP_ALU: begin
          case (op[3:0])
            c8_exec_pkg::ALU_LD:  vreg[x] = vy;
            c8_exec_pkg::ALU_OR:  vreg[x] = vx | vy;
            c8_exec_pkg::ALU_AND: vreg[x] = vx & vy;
            c8_exec_pkg::ALU_XOR: vreg[x] = vx ^ vy;
            c8_exec_pkg::ALU_ADD: begin
              sum = {1'b0, vx} + {1'b0, vy};
              write_flag(x, sum[7:0], sum[8]);
            end
            c8_exec_pkg::ALU_SUB:  write_flag(x, vx - vy, vx > vy);
            c8_exec_pkg::ALU_SHR:  write_flag(x, vx >> 1, vx[0]);
            c8_exec_pkg::ALU_SUBN: write_flag(x, vy - vx, vy > vx);
            c8_exec_pkg::ALU_SHL:  write_flag(x, vx << 1, vx[7]);
            default: ;
          endcase
        end
        c8_exec_pkg::GRP_SNER: if (vx != vy) npc = skp;
        c8_exec_pkg::GRP_LDIX: ireg = nnn;
        c8_exec_pkg::GRP_JPV0: npc = {4'h0, vreg[c8_exec_pkg::ZERO_REG]} + nnn;
        c8_exec_pkg::GRP_RND:  vreg[x] = it.random_byte & kk;
        default: ;
      endcase
      pc = npc;
      if (err == c8_exec_pkg::ERR_OVERFLOW) n_overflow++;
      if (err == c8_exec_pkg::ERR_UNDERFLOW) n_underflow++;
      if (cls) n_cls++;
      n_taken++;
      rep.next_pc      = npc;
      rep.clear_screen = cls;
      rep.stack_error  = err;
      rep.vx_value     = vreg[x];
      rep.vf_value     = vreg[c8_exec_pkg::FLAG_REG];
      rep.index_value  = ireg;
      reports_due.push_back(rep);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: mismatch %s expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    // Check one report against the oldest prediction
    function void check_report(c8_exec_pkg::out_item_t got);
      c8_exec_pkg::out_item_t want;
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        return;
      end
      want = reports_due.pop_front();
      n_checked++;
      compare("next_pc", want.next_pc, got.next_pc);
      compare("clear_screen", want.clear_screen, got.clear_screen);
      compare("stack_error", want.stack_error, got.stack_error);
      compare("vx_value", want.vx_value, got.vx_value);
      compare("vf_value", want.vf_value, got.vf_value);
      compare("index_value", want.index_value, got.index_value);
    endfunction
  endclass

  // Directed opcodes: extremes, every ALU code, flag destination, wraps
  localparam logic [15:0] DIRECTED_OPS [30] = '{
    16'h00E0, 16'h00EE, 16'h60FF, 16'hBFFF, 16'h7001, 16'h61FF, 16'h6201,
    16'h8124, 16'h8125, 16'h8127, 16'h6381, 16'h8306, 16'h830E, 16'h8F34,
    16'h8120, 16'h8121, 16'h8122, 16'h8123, 16'h8128, 16'h3302, 16'h4300,
    16'h511F, 16'h912F, 16'hAFFF, 16'hC3FF, 16'h2FFF, 16'h00EE, 16'h0FFF,
    16'h1000, 16'hF107
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  c8_exec_pkg::in_item_t  in_data;
  logic                   out_valid;
  logic                   out_stall;
  c8_exec_pkg::out_item_t out_data;

  exec_tracker trk;
  int          cycles;
  int          wait_left;
  bit          idle_on;
  bit          hold_req;
  int          hold_count;

  chip8_instruction_execute_top #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $time, trk.reports_due.size());
      $display("chip8_instruction_execute_top_tb: done, errors");
      $finish;
    end
  end

  // Check each report transfer and draw the next output stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      trk.check_report(out_data);
      wait_left = idle_on ? $urandom_range(0, 4) : 0;
    end
  end

  // Drive out_stall: per-report waits, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_count = 1;
        while (hold_count < LONG_HOLD) begin
          @(negedge clk);
          hold_count++;
        end
        hold_req = 1'b0;
      end else if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one opcode after a random gap and hold it until the transfer
  task automatic send_op(c8_exec_pkg::in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    trk.take_opcode(it);
  endtask

  // Pick an opcode, steering compares toward the tracked register values
  function automatic c8_exec_pkg::in_item_t pick_op();
    c8_exec_pkg::in_item_t it;
    int         sel;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] kk;
    x = 4'($urandom_range(0, 15));
    y = ($urandom_range(0, 2) == 0) ? x : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 4))
      0:       kk = 8'h00;
      1:       kk = 8'hFF;
      2:       kk = 8'h80;
      3:       kk = 8'h01;
      default: kk = 8'($urandom);
    endcase
    it.random_byte = 8'($urandom);
    it.opcode      = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 5)       it.opcode = c8_exec_pkg::OP_CLS;
    else if (sel < 11) it.opcode = c8_exec_pkg::OP_RET;
    else if (sel < 15) it.opcode[15:12] = c8_exec_pkg::GRP_SYS;
    else if (sel < 19) it.opcode[15:12] = c8_exec_pkg::GRP_JP;
    else if (sel < 26) it.opcode[15:12] = c8_exec_pkg::GRP_CALL;
    else if (sel < 32)
      it.opcode = {c8_exec_pkg::GRP_SEI, x, $urandom_range(0, 1) ? trk.vreg[x] : kk};
    else if (sel < 37)
      it.opcode = {c8_exec_pkg::GRP_SNEI, x, $urandom_range(0, 1) ? trk.vreg[x] : kk};
    else if (sel < 42) it.opcode = {c8_exec_pkg::GRP_SER, x, y, 4'($urandom)};
    else if (sel < 50) it.opcode = {c8_exec_pkg::GRP_LDI, x, kk};
    else if (sel < 56) it.opcode = {c8_exec_pkg::GRP_ADDI, x, kk};
    else if (sel < 78) it.opcode = {c8_exec_pkg::GRP_ALU, x, y, 4'($urandom)};
    else if (sel < 83) it.opcode = {c8_exec_pkg::GRP_SNER, x, y, 4'($urandom)};
    else if (sel < 87) it.opcode[15:12] = c8_exec_pkg::GRP_LDIX;
    else if (sel < 90) it.opcode[15:12] = c8_exec_pkg::GRP_JPV0;
    else if (sel < 95) it.opcode = {c8_exec_pkg::GRP_RND, x, kk};
    else               it.opcode[15:12] = 4'($urandom_range(13, 15));
    return it;
  endfunction

  // Nested calls followed by returns, deep enough to overflow or underflow
  task automatic call_burst(int n_calls, int n_rets);
    c8_exec_pkg::in_item_t it;
    repeat (n_calls) begin
      it.opcode      = {c8_exec_pkg::GRP_CALL, 12'($urandom)};
      it.random_byte = 8'($urandom);
      send_op(it);
    end
    repeat (n_rets) begin
      it.opcode      = c8_exec_pkg::OP_RET;
      it.random_byte = 8'($urandom);
      send_op(it);
    end
  endtask

  task automatic random_run(int n_ops);
    int sent;
    int n_calls;
    int n_rets;
    sent = 0;
    while (sent < n_ops) begin
      if ($urandom_range(0, 59) == 0) begin
        n_calls = $urandom_range(2, DEPTH + 3);
        n_rets  = $urandom_range(1, DEPTH + 3);
        call_burst(n_calls, n_rets);
        sent += n_calls + n_rets;
      end else begin
        send_op(pick_op());
        sent++;
      end
    end
  endtask

  task automatic wait_drained(int max_cycles);
    int n;
    n = 0;
    while (trk.reports_due.size() != 0 && n < max_cycles) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Main sequence
  initial begin
    c8_exec_pkg::in_item_t it;
    trk       = new();
    cycles    = 0;
    wait_left = 0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opcodes with the random byte at both extremes
    foreach (DIRECTED_OPS[i]) begin
      it.opcode      = DIRECTED_OPS[i];
      it.random_byte = i[0] ? 8'hFF : 8'h00;
      send_op(it);
    end

    // Overflow the stack, then unwind past empty
    call_burst(DEPTH + 2, DEPTH + 2);
    random_run(450);

    // Long output hold-off while opcodes keep coming back to back
    idle_on  = 1'b0;
    hold_req = 1'b1;
    random_run(40);
    idle_on = 1'b1;

    // Pause input until every report is back
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained(LIMIT);
    random_run(150);

    // Stretch with no idling on either side
    idle_on = 1'b0;
    random_run(250);
    idle_on = 1'b1;
    random_run(300);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained(2000);
    repeat (8) @(posedge clk);
    if (trk.reports_due.size() != 0) begin
      trk.errors++;
      $display("%0t: %0d reports never arrived", $time, trk.reports_due.size());
    end

    $display("Ran %0d opcodes and checked %0d reports over %0d cycles.",
             trk.n_taken, trk.n_checked, cycles);
    $display("Saw %0d call overflows, %0d return underflows, %0d screen clears.",
             trk.n_overflow, trk.n_underflow, trk.n_cls);
    if (trk.errors == 0) begin
      $display("chip8_instruction_execute_top_tb: done, clean");
    end else begin
      $display("chip8_instruction_execute_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/c8_exec_pkg.sv
hw/rtl/c8_exec_regfile.sv
hw/rtl/c8_exec_stack.sv
hw/rtl/chip8_instruction_execute_top.sv
tb/chip8_instruction_execute_top_tb.sv
